@@ src/battery_soc_ocv_interpolator_assert.svh @@
// assertion macros for the state of charge interpolator checker
`ifndef BATTERY_SOC_OCV_INTERPOLATOR_ASSERT_SVH
`define BATTERY_SOC_OCV_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define BSOC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bsoc check failed");

// next-cycle implication, sampled on clock, off during reset
`define BSOC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bsoc check failed");

`endif

@@ src/bsoc_pkg.sv @@
package bsoc_pkg;

   localparam int MAX_POINTS    = 12;
   localparam int VOLT_W        = 16;
   localparam int CELL_W        = 4;
   localparam int COUNT_W       = 4;
   localparam int PCT_W         = 7;
   localparam int REG_W         = 64;
   localparam int CSR_IDX_W     = 3;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 8;
   localparam int TABLE_WORDS   = 3;
   localparam int PROD_W        = VOLT_W + COUNT_W;
   localparam int SCALED_W      = PROD_W + PCT_W;
   localparam int VOLT_STEP_W   = $clog2(VOLT_W);
   localparam int MUL_STEP_W    = $clog2(COUNT_W);
   localparam int RATIO_STEP_W  = $clog2(PCT_W);

   localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
   localparam logic [PCT_W-1:0] PCT_EMPTY = PCT_W'(0);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CELL_COUNT   = 3'd0,
      REG_POINT_COUNT  = 3'd1,
      REG_POINTS_LOW   = 3'd2,
      REG_POINTS_MID   = 3'd3,
      REG_POINTS_HIGH  = 3'd4
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_MULT,
      ST_RATIO,
      ST_FINISH
   } state_type;

endpackage

@@ src/bsoc_cell_div.sv @@
module bsoc_cell_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bsoc_pkg::VOLT_W-1:0]   dividend,
   input  logic [bsoc_pkg::CELL_W-1:0]   divisor,
   output logic                          done,
   output logic [bsoc_pkg::VOLT_W-1:0]   quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [bsoc_pkg::VOLT_STEP_W-1:0]   step_ff, step_in;
   logic [bsoc_pkg::VOLT_W-1:0]        shift_ff, shift_in;
   logic [bsoc_pkg::CELL_W-1:0]        rem_ff, rem_in;
   logic [bsoc_pkg::CELL_W-1:0]        div_ff, div_in;
   logic [bsoc_pkg::CELL_W:0]          trial;
   logic [bsoc_pkg::CELL_W:0]          trial_sub;
   logic                               fits;

   always_comb begin
      trial     = {rem_ff, shift_ff[bsoc_pkg::VOLT_W-1]};
      trial_sub = trial - {1'b0, div_ff};
      fits      = (trial >= {1'b0, div_ff});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      shift_in  = shift_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? trial_sub[bsoc_pkg::CELL_W-1:0] : trial[bsoc_pkg::CELL_W-1:0];
         shift_in = {shift_ff[bsoc_pkg::VOLT_W-2:0], fits};
         step_in  = step_ff + 1'b1;
         if (step_ff == bsoc_pkg::VOLT_STEP_W'(bsoc_pkg::VOLT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

@@ src/bsoc_mul_serial.sv @@
module bsoc_mul_serial (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bsoc_pkg::VOLT_W-1:0]   mcand,
   input  logic [bsoc_pkg::COUNT_W-1:0]  mult_a,
   input  logic [bsoc_pkg::COUNT_W-1:0]  mult_b,
   output logic                          done,
   output logic [bsoc_pkg::PROD_W-1:0]   prod_a,
   output logic [bsoc_pkg::PROD_W-1:0]   prod_b
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [bsoc_pkg::MUL_STEP_W-1:0]    step_ff, step_in;
   logic [bsoc_pkg::PROD_W-1:0]        mcand_ff, mcand_in;
   logic [bsoc_pkg::COUNT_W-1:0]       ma_ff, ma_in;
   logic [bsoc_pkg::COUNT_W-1:0]       mb_ff, mb_in;
   logic [bsoc_pkg::PROD_W-1:0]        acc_a_ff, acc_a_in;
   logic [bsoc_pkg::PROD_W-1:0]        acc_b_ff, acc_b_in;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      mcand_in = mcand_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         mcand_in = bsoc_pkg::PROD_W'(mcand);
         ma_in    = mult_a;
         mb_in    = mult_b;
         acc_a_in = '0;
         acc_b_in = '0;
      end else if (busy_ff) begin
         // one multiplier bit per cycle
         acc_a_in = ma_ff[0] ? acc_a_ff + mcand_ff : acc_a_ff;
         acc_b_in = mb_ff[0] ? acc_b_ff + mcand_ff : acc_b_ff;
         mcand_in = {mcand_ff[bsoc_pkg::PROD_W-2:0], 1'b0};
         ma_in    = {1'b0, ma_ff[bsoc_pkg::COUNT_W-1:1]};
         mb_in    = {1'b0, mb_ff[bsoc_pkg::COUNT_W-1:1]};
         step_in  = step_ff + 1'b1;
         if (step_ff == bsoc_pkg::MUL_STEP_W'(bsoc_pkg::COUNT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      mcand_ff <= mcand_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
   end

   assign done   = done_ff;
   assign prod_a = acc_a_ff;
   assign prod_b = acc_b_ff;

endmodule

@@ src/bsoc_ratio_div.sv @@
module bsoc_ratio_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bsoc_pkg::PROD_W-1:0]   num,
   input  logic [bsoc_pkg::PROD_W-1:0]   den,
   output logic                          done,
   output logic [bsoc_pkg::PCT_W-1:0]    quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [bsoc_pkg::RATIO_STEP_W-1:0]  step_ff, step_in;
   logic [bsoc_pkg::SCALED_W-1:0]      rem_ff, rem_in;
   logic [bsoc_pkg::SCALED_W-1:0]      dsh_ff, dsh_in;
   logic [bsoc_pkg::PCT_W-1:0]         quo_ff, quo_in;
   logic                               fits;

   always_comb begin
      fits    = (rem_ff >= dsh_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         // numerator scaled to percent; quotient is known to stay below 100
         rem_in  = bsoc_pkg::SCALED_W'(num) * bsoc_pkg::SCALED_W'(bsoc_pkg::PCT_FULL);
         dsh_in  = bsoc_pkg::SCALED_W'(den) << (bsoc_pkg::PCT_W - 1);
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_ff - dsh_ff : rem_ff;
         quo_in  = {quo_ff[bsoc_pkg::PCT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff + 1'b1;
         if (step_ff == bsoc_pkg::RATIO_STEP_W'(bsoc_pkg::PCT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/battery_soc_ocv_interpolator.sv @@
// channel   direction  payload (lowest bit first)
// req       in         tdata: pack_voltage_mv[15:0]
// rsp       out        tdata: charge_percent[6:0], zero pad [7]
// csr       in         csr_index selects register 0..4, csr_wdata up to 64 bits
//
// from acceptance to the next acceptance a request goes through these steps: the accept, the
// bit-serial cell divide, a compare per table point (one more if none matches), the serial
// multiply and the ratio divide when interpolating, then the load of rsp, which waits on rsp_tready.
// one request is in work at a time; the next is taken once the result is in the output
// register, even while that result still waits on rsp_tready.
// reset is synchronous: config returns to one cell, empty table, no pending result.
module battery_soc_ocv_interpolator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bsoc_pkg::REQ_DATA_W-1:0]   req_tdata,   // pack_voltage_mv
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bsoc_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // charge_percent, pad
   input  logic                              csr_we,
   input  logic [bsoc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsoc_pkg::REG_W-1:0]        csr_wdata
);

   bsoc_pkg::state_type                state_ff, state_in;

   logic [bsoc_pkg::CELL_W-1:0]        cell_count_ff, cell_count_in;
   logic [bsoc_pkg::COUNT_W-1:0]       point_count_ff, point_count_in;
   logic [bsoc_pkg::REG_W-1:0]         table_ff [bsoc_pkg::TABLE_WORDS];
   logic [bsoc_pkg::REG_W-1:0]         table_in [bsoc_pkg::TABLE_WORDS];

   logic [bsoc_pkg::COUNT_W-1:0]       idx_ff, idx_in;
   logic [bsoc_pkg::COUNT_W-1:0]       n_ff, n_in;
   logic [bsoc_pkg::VOLT_W-1:0]        volt_ff, volt_in;
   logic [bsoc_pkg::VOLT_W-1:0]        prev_ff, prev_in;
   logic [bsoc_pkg::VOLT_W-1:0]        gap_ff, gap_in;
   logic [bsoc_pkg::PCT_W-1:0]         res_ff, res_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bsoc_pkg::PCT_W-1:0]         rsp_data_ff, rsp_data_in;

   logic [bsoc_pkg::CELL_W-1:0]        cells;
   logic [bsoc_pkg::COUNT_W-1:0]       n_sat;
   logic [bsoc_pkg::REG_W-1:0]         word;
   logic [bsoc_pkg::VOLT_W-1:0]        point;
   logic [bsoc_pkg::VOLT_W-1:0]        diff;
   logic                               scan_end;
   logic                               hit;
   logic                               hit_full;

   logic                               div_start, div_done;
   logic [bsoc_pkg::VOLT_W-1:0]        div_quotient;
   logic                               mul_start, mul_done;
   logic [bsoc_pkg::COUNT_W-1:0]       mult_a, mult_b;
   logic [bsoc_pkg::PROD_W-1:0]        prod_a, prod_b;
   logic                               ratio_start, ratio_done;
   logic [bsoc_pkg::PROD_W-1:0]        ratio_num;
   logic [bsoc_pkg::PCT_W-1:0]         ratio_quotient;
   logic                               load_rsp;

   // configuration registers
   always_comb begin
      cell_count_in  = cell_count_ff;
      point_count_in = point_count_ff;
      table_in       = table_ff;
      if (csr_we) begin
         unique case (bsoc_pkg::csr_reg_type'(csr_index))
            bsoc_pkg::REG_CELL_COUNT:  cell_count_in  = csr_wdata[bsoc_pkg::CELL_W-1:0];
            bsoc_pkg::REG_POINT_COUNT: point_count_in = csr_wdata[bsoc_pkg::COUNT_W-1:0];
            bsoc_pkg::REG_POINTS_LOW:  table_in[0]    = csr_wdata;
            bsoc_pkg::REG_POINTS_MID:  table_in[1]    = csr_wdata;
            bsoc_pkg::REG_POINTS_HIGH: table_in[2]    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // table point under the scan index
   always_comb begin
      unique case (idx_ff[3:2])
         2'd0:    word = table_ff[0];
         2'd1:    word = table_ff[1];
         2'd2:    word = table_ff[2];
         default: word = '0;
      endcase
      point    = word[{idx_ff[1:0], 4'b0000} +: bsoc_pkg::VOLT_W];
      diff     = (prev_ff > point) ? prev_ff - point : '0;
      scan_end = (idx_ff == n_ff);
      hit      = !scan_end && (point <= volt_ff);
      hit_full = (idx_ff == '0) || (diff == '0);
      cells    = (cell_count_ff == '0) ? bsoc_pkg::CELL_W'(1) : cell_count_ff;
      n_sat    = (point_count_ff > bsoc_pkg::COUNT_W'(bsoc_pkg::MAX_POINTS)) ?
                 bsoc_pkg::COUNT_W'(bsoc_pkg::MAX_POINTS) : point_count_ff;
      mult_a   = n_ff - 1'b1 - idx_ff;
      mult_b   = n_ff - 1'b1;
      ratio_num = prod_a + bsoc_pkg::PROD_W'(gap_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bsoc_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = bsoc_pkg::ST_DIVIDE;
         end
         bsoc_pkg::ST_DIVIDE: begin
            if (div_done) state_in = bsoc_pkg::ST_SCAN;
         end
         bsoc_pkg::ST_SCAN: begin
            if (scan_end || (hit && hit_full)) state_in = bsoc_pkg::ST_FINISH;
            else if (hit) state_in = bsoc_pkg::ST_MULT;
         end
         bsoc_pkg::ST_MULT: begin
            if (mul_done) state_in = bsoc_pkg::ST_RATIO;
         end
         bsoc_pkg::ST_RATIO: begin
            if (ratio_done) state_in = bsoc_pkg::ST_FINISH;
         end
         bsoc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) state_in = bsoc_pkg::ST_IDLE;
         end
         default: state_in = bsoc_pkg::ST_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      req_tready  = (state_ff == bsoc_pkg::ST_IDLE);
      div_start   = (state_ff == bsoc_pkg::ST_IDLE) && req_tvalid;
      mul_start   = (state_ff == bsoc_pkg::ST_SCAN) && hit && !hit_full;
      ratio_start = (state_ff == bsoc_pkg::ST_MULT) && mul_done;
      load_rsp    = (state_ff == bsoc_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   end

   // datapath
   always_comb begin
      idx_in       = idx_ff;
      n_in         = n_ff;
      volt_in      = volt_ff;
      prev_in      = prev_ff;
      gap_in       = gap_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (div_start) begin
         idx_in = '0;
         n_in   = n_sat;
      end
      if ((state_ff == bsoc_pkg::ST_DIVIDE) && div_done) begin
         volt_in = div_quotient;
      end
      if (state_ff == bsoc_pkg::ST_SCAN) begin
         prev_in = point;
         gap_in  = volt_ff - point;
         if (scan_end) res_in = bsoc_pkg::PCT_EMPTY;
         else if (hit && hit_full) res_in = bsoc_pkg::PCT_FULL;
         else if (!hit) idx_in = idx_ff + 1'b1;
      end
      if ((state_ff == bsoc_pkg::ST_RATIO) && ratio_done) begin
         res_in = (ratio_quotient > bsoc_pkg::PCT_FULL) ? bsoc_pkg::PCT_FULL : ratio_quotient;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bsoc_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         cell_count_ff  <= bsoc_pkg::CELL_W'(1);
         point_count_ff <= '0;
         for (int w = 0; w < bsoc_pkg::TABLE_WORDS; w++) begin
            table_ff[w] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         cell_count_ff  <= cell_count_in;
         point_count_ff <= point_count_in;
         table_ff       <= table_in;
      end
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      volt_ff     <= volt_in;
      prev_ff     <= prev_in;
      gap_ff      <= gap_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   bsoc_cell_div u_cell_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata),
      .divisor  (cells),
      .done     (div_done),
      .quotient (div_quotient)
   );

   bsoc_mul_serial u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (diff),
      .mult_a (mult_a),
      .mult_b (mult_b),
      .done   (mul_done),
      .prod_a (prod_a),
      .prod_b (prod_b)
   );

   bsoc_ratio_div u_ratio_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ratio_start),
      .num      (ratio_num),
      .den      (prod_b),
      .done     (ratio_done),
      .quotient (ratio_quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

@@ src/bsoc_checker.sv @@
`include "battery_soc_ocv_interpolator_assert.svh"

module bsoc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bsoc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // result always a valid percentage with a clear pad bit
   `BSOC_ASSERT_NOW(a_pct_range, rsp_tvalid, (rsp_tdata[6:0] <= 7'd100) && !rsp_tdata[7])

   // one request in work at a time
   `BSOC_ASSERT_NEXT(a_one_in_work, req_tvalid && req_tready, !req_tready)

   // a new result appears exactly as the block goes back to taking requests
   `BSOC_ASSERT_NOW(a_rsp_with_ready, $rose(rsp_tvalid), req_tready)

   // stalled result holds
   `BSOC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind battery_soc_ocv_interpolator bsoc_checker u_bsoc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import bsoc_pkg::*;

   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_LIMIT      = 4000;
   localparam int SETTLE_CYCLES    = 60;
   localparam int RANDOM_PHASES    = 14;
   localparam int PHASE_REQUESTS   = 70;
   localparam int HOLD_REQUESTS    = 40;
   localparam int TIMEOUT_NS       = 5_000_000;
   localparam int PRINT_LIMIT      = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // pack_voltage_mv[15:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // charge_percent[6:0], zero pad [7]
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_CELL_COUNT;
   logic [REG_W-1:0]      csr_wdata = '0;

   // register copies for the predictor
   logic [CELL_W-1:0]  mirror_cells = CELL_W'(1);
   logic [COUNT_W-1:0] mirror_points = '0;
   logic [REG_W-1:0]   mirror_words [TABLE_WORDS] = '{default: '0};
   logic [REG_W-1:0]   table_build [TABLE_WORDS];

   logic [PCT_W-1:0] charge_expected [$];
   logic [PCT_W-1:0] charge_want;

   int  fail_count = 0;
   int  sent_count = 0;
   int  results_seen = 0;
   int  table_loads = 0;
   int  burst_left = 0;
   bit  bursty = 1'b1;

   logic       long_stall_go = 1'b0;
   logic       hold_seen;
   int         hold_left;
   logic [7:0] pace_cycle;
   int         pace_mode;

   battery_soc_ocv_interpolator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int point_mv(input int idx);
      return int'(mirror_words[idx / 4][(idx % 4) * 16 +: 16]);
   endfunction

   function automatic logic [PCT_W-1:0] predict_charge(input logic [VOLT_W-1:0] mv);
      longint cells, n, v, p, prev, d, pct;
      bit     found;
      cells = (mirror_cells == 0) ? 1 : longint'(mirror_cells);
      n = (mirror_points > MAX_POINTS) ? MAX_POINTS : longint'(mirror_points);
      v = longint'(mv) / cells;
      pct = 0;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
         p = point_mv(i);
         if (!found && p <= v) begin
            found = 1'b1;
            if (i == 0) begin
               pct = 100;
            end else begin
               prev = point_mv(i - 1);
               d = (prev > p) ? prev - p : 0;
               if (d == 0) begin
                  pct = 100;
               end else begin
                  pct = (100 * ((n - 1 - i) * d + (v - p))) / ((n - 1) * d);
               end
            end
         end
      end
      if (pct > 100) begin
         pct = 100;
      end
      return PCT_W'(pct);
   endfunction

   // mostly voltages that land inside the loaded table, some anywhere
   function automatic logic [VOLT_W-1:0] pick_voltage();
      int cells, n, lo, hi, cell_mv, pack;
      cells = (mirror_cells == 0) ? 1 : int'(mirror_cells);
      n = (mirror_points > MAX_POINTS) ? MAX_POINTS : int'(mirror_points);
      if (n == 0 || $urandom_range(0, 4) == 0) begin
         return VOLT_W'($urandom_range(0, 65535));
      end
      hi = point_mv(0);
      lo = point_mv(n - 1);
      if (lo > hi) begin
         cell_mv = lo;
         lo = hi;
         hi = cell_mv;
      end
      if ($urandom_range(0, 3) == 0) begin
         cell_mv = point_mv($urandom_range(0, n - 1));
      end else begin
         cell_mv = $urandom_range((lo > 60) ? lo - 60 : 0, (hi < 65475) ? hi + 60 : 65535);
      end
      pack = cell_mv * cells + $urandom_range(0, cells - 1);
      if (pack > 65535) begin
         pack = 65535;
      end
      return VOLT_W'(pack);
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_CELL_COUNT:  mirror_cells = value[CELL_W-1:0];
         REG_POINT_COUNT: mirror_points = value[COUNT_W-1:0];
         REG_POINTS_LOW:  mirror_words[0] = value;
         REG_POINTS_MID:  mirror_words[1] = value;
         REG_POINTS_HIGH: mirror_words[2] = value;
         default: ;
      endcase
   endtask

   task automatic load_table(input logic [REG_W-1:0] cells_word,
                             input logic [REG_W-1:0] count_word,
                             input logic [REG_W-1:0] w0,
                             input logic [REG_W-1:0] w1,
                             input logic [REG_W-1:0] w2);
      write_reg(REG_CELL_COUNT, cells_word);
      write_reg(REG_POINT_COUNT, count_word);
      write_reg(REG_POINTS_LOW, w0);
      write_reg(REG_POINTS_MID, w1);
      write_reg(REG_POINTS_HIGH, w2);
      csr_we <= 1'b0;
      table_loads++;
   endtask

   task automatic make_descending(input int top, input int step_lo, input int step_hi);
      int mv;
      mv = top;
      for (int k = 0; k < MAX_POINTS; k++) begin
         table_build[k / 4][(k % 4) * 16 +: 16] = mv[15:0];
         mv = mv - $urandom_range(step_lo, step_hi);
         if (mv < 0) begin
            mv = 0;
         end
      end
   endtask

   task automatic send_voltage(input logic [VOLT_W-1:0] mv);
      int gap;
      if (bursty && burst_left == 0) begin
         case ($urandom_range(0, 3))
            0:       gap = 0;
            3:       gap = $urandom_range(9, 60);
            default: gap = $urandom_range(1, 8);
         endcase
         burst_left = $urandom_range(1, 16);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= mv;
      do @(posedge clock); while (!req_tready);
      charge_expected.push_back(predict_charge(mv));
      sent_count++;
   endtask

   task automatic wait_idle();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (charge_expected.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (charge_expected.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", charge_expected.size()));
         charge_expected.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // empty table after reset gives zero
   task automatic test_reset_defaults();
      send_voltage(16'd0);
      send_voltage(16'hFFFF);
      wait_idle();
   endtask

   task automatic test_table_match();
      load_table(1, 4, {16'd3300, 16'd3600, 16'd3900, 16'd4200}, '0, '0);
      send_voltage(16'd4200);
      send_voltage(16'hFFFF);
      send_voltage(16'd4000);
      send_voltage(16'd3600);
      send_voltage(16'd3300);
      send_voltage(16'd3299);
      send_voltage(16'd0);
      wait_idle();
   endtask

   task automatic test_cell_and_count();
      // zero cells acts as one cell
      load_table(0, 4, {16'd3300, 16'd3600, 16'd3900, 16'd4200}, '0, '0);
      send_voltage(16'd3750);
      wait_idle();
      // point count above the table size saturates
      make_descending(4200, 50, 150);
      load_table(15, 15, table_build[0], table_build[1], table_build[2]);
      send_voltage(16'hFFFF);
      send_voltage(VOLT_W'(15 * 3000 + 14));
      wait_idle();
      load_table(8, 12, table_build[0], table_build[1], table_build[2]);
      send_voltage(VOLT_W'(8 * 3450));
      wait_idle();
      // single point table
      load_table(1, 1, {48'd0, 16'd4200}, '0, '0);
      send_voltage(16'd4000);
      send_voltage(16'd4300);
      wait_idle();
   endtask

   // non-descending table and equal neighbors
   task automatic test_unsorted_table();
      load_table(1, 4, {16'd1000, 16'd4500, 16'd2000, 16'd4000}, '0, '0);
      send_voltage(16'd3000);
      send_voltage(16'd1500);
      wait_idle();
      load_table(1, 4, {16'd3000, 16'd3000, 16'd4000, 16'd4000}, '0, '0);
      send_voltage(16'd3500);
      wait_idle();
   endtask

   // writes to indexes past the last register change nothing
   task automatic test_unknown_index();
      load_table(2, 3, {16'd0, 16'd3000, 16'd3500, 16'd4000}, '0, '0);
      for (int k = int'(REG_POINTS_HIGH) + 1; k < 2 ** CSR_IDX_W; k++) begin
         write_reg(CSR_IDX_W'(k), '1);
      end
      csr_we <= 1'b0;
      send_voltage(VOLT_W'(2 * 3700));
      send_voltage(VOLT_W'(2 * 3200 + 1));
      wait_idle();
   endtask

   task automatic test_random_tables();
      int         cells, count;
      logic [63:0] cells_word, count_word;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin cells = 1;  count = 12; end
            1:       begin cells = 8;  count = 2;  end
            2:       begin cells = 15; count = 12; end
            3:       begin cells = 0;  count = 15; end
            4:       begin cells = 3;  count = 0;  end
            default: begin cells = $urandom_range(0, 15); count = $urandom_range(1, 15); end
         endcase
         case (phase % 4)
            1: make_descending($urandom_range(20000, 65535), 1, 6000);
            2: begin
               for (int w = 0; w < TABLE_WORDS; w++) begin
                  table_build[w] = {$urandom, $urandom};
               end
            end
            default: make_descending($urandom_range(3600, 4400), 10, 250);
         endcase
         if (phase == 6) begin
            table_build = '{default: '1};
         end
         cells_word = (phase % 2 == 1) ? {$urandom, $urandom} : '0;
         count_word = (phase % 2 == 1) ? {$urandom, $urandom} : '0;
         cells_word[CELL_W-1:0] = CELL_W'(cells);
         count_word[COUNT_W-1:0] = COUNT_W'(count);
         load_table(cells_word, count_word, table_build[0], table_build[1], table_build[2]);
         bursty = (phase % 5 != 4);
         for (int k = 0; k < PHASE_REQUESTS; k++) begin
            send_voltage(pick_voltage());
         end
         wait_idle();
      end
      bursty = 1'b1;
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_output_hold();
      make_descending(4200, 20, 200);
      load_table(4, 12, table_build[0], table_build[1], table_build[2]);
      bursty = 1'b0;
      long_stall_go <= ~long_stall_go;
      for (int k = 0; k < HOLD_REQUESTS; k++) begin
         send_voltage(pick_voltage());
      end
      bursty = 1'b1;
      wait_idle();
   endtask

   // receiver: long hold on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_seen  <= 1'b0;
         hold_left  <= 0;
         pace_cycle <= '0;
         pace_mode  <= 0;
      end else begin
         hold_seen  <= long_stall_go;
         pace_cycle <= pace_cycle + 1'b1;
         if (pace_cycle == 0) begin
            pace_mode <= $urandom_range(0, 3);
         end
         if (long_stall_go != hold_seen) begin
            hold_left  <= LONG_HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (pace_mode == 0) || ($urandom_range(0, pace_mode) == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (charge_expected.size() == 0) begin
            report_mismatch($sformatf("result 0x%0h with nothing pending", rsp_tdata));
         end else begin
            charge_want = charge_expected.pop_front();
            results_seen++;
            if (rsp_tdata !== RSP_DATA_W'(charge_want)) begin
               report_mismatch($sformatf("charge_percent got 0x%0h want %0d",
                                         rsp_tdata, charge_want));
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results pending", charge_expected.size());
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_table_match();
      test_cell_and_count();
      test_unsorted_table();
      test_unknown_index();
      test_random_tables();
      test_output_hold();
      $display("%0d requests over %0d table loads, %0d results checked, %0d mismatches",
               sent_count, table_loads, results_seen, fail_count);
      $display("cell counts 0 to 15, point counts 0 to 15, a %0d cycle output hold",
               LONG_HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/bsoc_pkg.sv
src/bsoc_cell_div.sv
src/bsoc_mul_serial.sv
src/bsoc_ratio_div.sv
src/battery_soc_ocv_interpolator.sv
src/bsoc_checker.sv
sim/tb.sv
